### sv/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

  localparam int PROCS     = 5;
  localparam int RES_KINDS = 3;
  localparam int UNIT_BITS = 8;

  // Widths of the item fields.
  localparam int TYPE_BITS   = 2;
  localparam int PROC_BITS   = 3;
  localparam int STATUS_BITS = 3;

  // The work vector holds the available units plus every allocation.
  localparam int WORK_BITS = UNIT_BITS + $clog2(PROCS + 1);

  // Request types.
  localparam logic [TYPE_BITS-1:0] REQ_INIT    = 2'd0;
  localparam logic [TYPE_BITS-1:0] REQ_DECLARE = 2'd1;
  localparam logic [TYPE_BITS-1:0] REQ_REQUEST = 2'd2;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_GRANTED    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_OVER_NEED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_OVER_AVAIL = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_UNSAFE     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_ACCEPTED   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_CLAIM_LOW  = 3'd5;

  // One input word.
  typedef struct packed {
    logic [TYPE_BITS-1:0]                 req_type;
    logic [PROC_BITS-1:0]                 process;
    logic [RES_KINDS-1:0][UNIT_BITS-1:0]  amount;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [STATUS_BITS-1:0]               status;
    logic [PROCS-1:0][PROC_BITS-1:0]      safe;
    logic [RES_KINDS-1:0][UNIT_BITS-1:0]  left;
  } out_word_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_DECLARE,
    OP_GRANT,
    OP_SCAN,
    OP_ROLLBACK,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t                  op;
    logic [STATUS_BITS-1:0]  status;
  } dp_cmd_t;

  typedef struct packed {
    logic [TYPE_BITS-1:0]    req_type;
    logic                    proc_ok;
    logic                    decl_low;
    logic [STATUS_BITS-1:0]  req_code;
    logic                    scan_safe;
    logic                    scan_stuck;
  } dp_sts_t;

endpackage

`default_nettype wire

### sv/bsa_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one request word per handshake.
interface bsa_in_if;
  import bsa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [TYPE_BITS-1:0]       req_type;
  logic [PROC_BITS-1:0]       process;
  logic [UNIT_BITS-1:0]       amount_0;
  logic [UNIT_BITS-1:0]       amount_1;
  logic [UNIT_BITS-1:0]       amount_2;

  modport source (output valid, req_type, process, amount_0, amount_1, amount_2,
                  input ready);
  modport sink   (input valid, req_type, process, amount_0, amount_1, amount_2,
                  output ready);
endinterface

// Result channel: one result word per handshake.
interface bsa_out_if;
  import bsa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_BITS-1:0]     status;
  logic [PROC_BITS-1:0]       safe_0;
  logic [PROC_BITS-1:0]       safe_1;
  logic [PROC_BITS-1:0]       safe_2;
  logic [PROC_BITS-1:0]       safe_3;
  logic [PROC_BITS-1:0]       safe_4;
  logic [UNIT_BITS-1:0]       left_0;
  logic [UNIT_BITS-1:0]       left_1;
  logic [UNIT_BITS-1:0]       left_2;

  modport source (output valid, status, safe_0, safe_1, safe_2, safe_3, safe_4,
                  left_0, left_1, left_2, input ready);
  modport sink   (input valid, status, safe_0, safe_1, safe_2, safe_3, safe_4,
                  left_0, left_1, left_2, output ready);
endinterface

`default_nettype wire

### sv/bsa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bsa_datapath
  import bsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_word_t   in_word,
  input  wire dp_cmd_t    cmd,
  output dp_sts_t         sts,
  output out_word_t       out_word
);

  // Captured input word.
  logic [TYPE_BITS-1:0]  type_r;
  logic [PROC_BITS-1:0]  proc_r;
  logic [UNIT_BITS-1:0]  amt_r [RES_KINDS];

  // Allocator state. A row that is not valid reads as all zero.
  logic [UNIT_BITS-1:0]  avail_r [RES_KINDS];
  logic [UNIT_BITS-1:0]  alloc_r [PROCS][RES_KINDS];
  logic [UNIT_BITS-1:0]  need_r  [PROCS][RES_KINDS];
  logic [PROCS-1:0]      row_vld_r;

  // Safety scan state.
  logic [WORK_BITS-1:0]  work_r  [RES_KINDS];
  logic [PROCS-1:0]      done_r;
  logic [PROC_BITS-1:0]  order_r [PROCS];
  logic [PROC_BITS-1:0]  pass_r;
  logic [PROC_BITS-1:0]  ptr_r;

  out_word_t             out_r;

  logic                  proc_ok;
  logic [PROC_BITS-1:0]  rd_idx;
  logic [UNIT_BITS-1:0]  rd_alloc [RES_KINDS];
  logic [UNIT_BITS-1:0]  rd_need  [RES_KINDS];
  logic [UNIT_BITS-1:0]  scan_alloc [RES_KINDS];
  logic [UNIT_BITS-1:0]  scan_need  [RES_KINDS];
  logic                  decl_low;
  logic                  fail_found;
  logic [STATUS_BITS-1:0] req_code;
  logic                  fits;

  assign proc_ok = (proc_r < PROC_BITS'(PROCS));

  // The process row serves the checks and the table updates.
  always_comb begin
    if (proc_ok) begin
      rd_idx = proc_r;
    end else begin
      rd_idx = '0;
    end
  end

  // Process row and scan row, each zero while the row is not valid.
  always_comb begin
    for (int r = 0; r < RES_KINDS; r++) begin
      rd_alloc[r]   = row_vld_r[rd_idx] ? alloc_r[rd_idx][r] : '0;
      rd_need[r]    = row_vld_r[rd_idx] ? need_r[rd_idx][r]  : '0;
      scan_alloc[r] = row_vld_r[ptr_r]  ? alloc_r[ptr_r][r]  : '0;
      scan_need[r]  = row_vld_r[ptr_r]  ? need_r[ptr_r][r]   : '0;
    end
  end

  // Declare check: any claim below the current allocation.
  always_comb begin
    decl_low = 1'b0;
    for (int r = 0; r < RES_KINDS; r++) begin
      if (amt_r[r] < rd_alloc[r]) begin
        decl_low = 1'b1;
      end
    end
  end

  // Request check: kinds in order, need before available, first failure wins.
  always_comb begin
    fail_found = 1'b0;
    req_code   = ST_GRANTED;
    for (int r = 0; r < RES_KINDS; r++) begin
      if (!fail_found) begin
        if (amt_r[r] > rd_need[r]) begin
          fail_found = 1'b1;
          req_code   = ST_OVER_NEED;
        end else if (amt_r[r] > avail_r[r]) begin
          fail_found = 1'b1;
          req_code   = ST_OVER_AVAIL;
        end
      end
    end
  end

  // Scan step: does the process under the pointer fit the work vector?
  always_comb begin
    fits = !done_r[ptr_r];
    for (int r = 0; r < RES_KINDS; r++) begin
      if (work_r[r] < WORK_BITS'(scan_need[r])) begin
        fits = 1'b0;
      end
    end
  end

  always_comb begin
    sts.req_type   = type_r;
    sts.proc_ok    = proc_ok;
    sts.decl_low   = decl_low;
    sts.req_code   = req_code;
    sts.scan_safe  = fits && (pass_r == PROC_BITS'(PROCS - 1));
    sts.scan_stuck = !fits && (ptr_r == PROC_BITS'(PROCS - 1));
  end

  // Row valid bits: cleared by reset and by init, set on a declare or a grant.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.op == OP_INIT) begin
      row_vld_r <= '0;
    end else if ((cmd.op == OP_DECLARE) || (cmd.op == OP_GRANT)) begin
      row_vld_r[rd_idx] <= 1'b1;
    end
  end

  // Available vector: reset to zero, loaded by init, lowered by a grant, raised by a rollback.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < RES_KINDS; r++) begin
        avail_r[r] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_INIT: begin
          for (int r = 0; r < RES_KINDS; r++) begin
            avail_r[r] <= amt_r[r];
          end
        end
        OP_GRANT: begin
          for (int r = 0; r < RES_KINDS; r++) begin
            avail_r[r] <= avail_r[r] - amt_r[r];
          end
        end
        OP_ROLLBACK: begin
          for (int r = 0; r < RES_KINDS; r++) begin
            avail_r[r] <= avail_r[r] + amt_r[r];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Input capture, table rows, scan state and the output register.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        type_r <= in_word.req_type;
        proc_r <= in_word.process;
        for (int r = 0; r < RES_KINDS; r++) begin
          amt_r[r] <= in_word.amount[r];
        end
      end
      OP_DECLARE: begin
        for (int r = 0; r < RES_KINDS; r++) begin
          alloc_r[rd_idx][r] <= rd_alloc[r];
          need_r[rd_idx][r]  <= amt_r[r] - rd_alloc[r];
        end
      end
      OP_GRANT: begin
        for (int r = 0; r < RES_KINDS; r++) begin
          alloc_r[rd_idx][r] <= rd_alloc[r] + amt_r[r];
          need_r[rd_idx][r]  <= rd_need[r] - amt_r[r];
          work_r[r]          <= WORK_BITS'(avail_r[r] - amt_r[r]);
        end
        done_r <= '0;
        pass_r <= '0;
        ptr_r  <= '0;
      end
      OP_SCAN: begin
        if (fits) begin
          for (int r = 0; r < RES_KINDS; r++) begin
            work_r[r] <= work_r[r] + WORK_BITS'(scan_alloc[r]);
          end
          done_r[ptr_r]   <= 1'b1;
          order_r[pass_r] <= ptr_r;
          pass_r          <= pass_r + 1'b1;
          ptr_r           <= '0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      OP_ROLLBACK: begin
        for (int r = 0; r < RES_KINDS; r++) begin
          alloc_r[rd_idx][r] <= rd_alloc[r] - amt_r[r];
          need_r[rd_idx][r]  <= rd_need[r] + amt_r[r];
        end
      end
      OP_FINISH: begin
        out_r.status <= cmd.status;
        for (int p = 0; p < PROCS; p++) begin
          out_r.safe[p] <= (cmd.status == ST_GRANTED) ? order_r[p] : '0;
        end
        for (int r = 0; r < RES_KINDS; r++) begin
          out_r.left[r] <= avail_r[r];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

### sv/bsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bsa_ctrl
  import bsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_sts_t  sts,
  output dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DECODE   = 5'b00010,
    S_SCAN     = 5'b00100,
    S_ROLLBACK = 5'b01000,
    S_FINISH   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [STATUS_BITS-1:0]  status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Next state, status code and datapath command.
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.status    = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt  = S_FINISH;
        status_nxt = ST_ACCEPTED;
        case (sts.req_type)
          REQ_INIT: begin
            cmd.op = OP_INIT;
          end
          REQ_DECLARE: begin
            if (!sts.proc_ok) begin
              status_nxt = ST_OVER_NEED;
            end else if (sts.decl_low) begin
              status_nxt = ST_CLAIM_LOW;
            end else begin
              cmd.op = OP_DECLARE;
            end
          end
          REQ_REQUEST: begin
            if (!sts.proc_ok) begin
              status_nxt = ST_OVER_NEED;
            end else if (sts.req_code != ST_GRANTED) begin
              status_nxt = sts.req_code;
            end else begin
              cmd.op    = OP_GRANT;
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_safe) begin
          status_nxt = ST_GRANTED;
          state_nxt  = S_FINISH;
        end else if (sts.scan_stuck) begin
          status_nxt = ST_UNSAFE;
          state_nxt  = S_ROLLBACK;
        end
      end
      S_ROLLBACK: begin
        cmd.op    = OP_ROLLBACK;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_ACCEPTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted word is decoded in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=>
      (state_r == S_FINISH && out_valid_r))
    else $error("result register overwritten");

  // The scan cannot end both safe and stuck.
  a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !(sts.scan_safe && sts.scan_stuck))
    else $error("scan ended both safe and unsafe");

  // A rollback always reports an unsafe state.
  a_rollback_unsafe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROLLBACK) |-> (status_r == ST_UNSAFE))
    else $error("rollback without unsafe status");

endmodule

`default_nettype wire

### sv/banker_safety_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Init, declare and rejected requests pass from decode straight to finish, where the result is loaded.
// A checked request runs the safety scan, one process row per cycle: a safe scan ends when every
// process is placed in the safe order; an unsafe one stops when no row is left that fits, and rolls back.
// The block takes one word at a time; the next word can be taken in the cycle after the
// result is loaded, and a result that waits for out_ready holds the block in its last state.
// Reset (rst_n low, synchronous) clears the available vector and marks every table row empty.
module banker_safety_allocator_core
  import bsa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsa_in_if.sink     in_ch,
  bsa_out_if.source  out_ch
);

  in_word_t   in_word;
  out_word_t  out_word;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  // Pack the input channel into one word.
  always_comb begin
    in_word.req_type  = in_ch.req_type;
    in_word.process   = in_ch.process;
    in_word.amount[0] = in_ch.amount_0;
    in_word.amount[1] = in_ch.amount_1;
    in_word.amount[2] = in_ch.amount_2;
  end

  bsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsa_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

  // Unpack the result word onto the output channel.
  assign out_ch.status = out_word.status;
  assign out_ch.safe_0 = out_word.safe[0];
  assign out_ch.safe_1 = out_word.safe[1];
  assign out_ch.safe_2 = out_word.safe[2];
  assign out_ch.safe_3 = out_word.safe[3];
  assign out_ch.safe_4 = out_word.safe[4];
  assign out_ch.left_0 = out_word.left[0];
  assign out_ch.left_1 = out_word.left[1];
  assign out_ch.left_2 = out_word.left[2];

endmodule

`default_nettype wire
